[design/smstt_pkg.sv]
// Shared types and codes for the sorted coordinate-list sparse matrix table.
// No dependencies; imported by the top level sparse_matrix_sorted_triple_table.
package smstt_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int NZ_W    = 7;
    localparam int DIM_W   = 11;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_COUNT  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;
    localparam logic [NZ_W-1:0]  NZ_MAX    = 7'd127;

    typedef struct packed {
        logic [INDEX_W-1:0]        row;
        logic [INDEX_W-1:0]        col;
        logic signed [VALUE_W-1:0] val;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_DECIDE = 6'b000100,
        S_DEL    = 6'b001000,
        S_INS    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

endpackage

[design/sparse_matrix_sorted_triple_table.sv]
// Sparse matrix table: sorted (row, column, value) entries in a single-port-write memory.
// A small sequencer scans the table once to locate a key, then shifts entries on insert or delete.
// Depends on smstt_pkg. The search reads the stored entries (at most MAX_ENTRIES) in order until
// the key is found or passed, and a write that inserts or deletes then shifts the entries after
// its position; one table slot is read per cycle through the registered memory port. One
// transaction at a time; input is ready again in the cycle after the result is accepted.
// Reset clears the entry count and sets both dimension registers to 1024; table contents need none.
module sparse_matrix_sorted_triple_table
    import smstt_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_DIM     = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // opcode[1:0], row_index[11:2], column_index[21:12],
                                   // write_value[53:22], zero[55:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // element_value[31:0], row_nonzeros[38:32],
                                   // status[40:39], zero[47:41]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);
    localparam logic [16:0]   MAX_DIM_W  = 17'(MAX_DIM);

    entry_t entry_mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] row_count_reg, column_count_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] wdest_reg, wdest_next;
    logic          pend_reg, pend_next;
    logic          hit_reg, hit_next;
    logic [1:0]          op_reg, op_next;
    logic [INDEX_W-1:0]  row_reg, row_next;
    logic [INDEX_W-1:0]  col_reg, col_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [VALUE_W-1:0] old_val_reg, old_val_next;
    logic [NZ_W-1:0]     nz_reg, nz_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [NZ_W-1:0]     res_nz_reg, res_nz_next;
    logic [1:0]          res_status_reg, res_status_next;

    logic [1:0]         in_op;
    logic [INDEX_W-1:0] in_row;
    logic [INDEX_W-1:0] in_col;
    logic [VALUE_W-1:0] in_val;
    logic row_ok, col_ok, in_err;
    logic key_hit, key_lt, stop;
    logic cfg_write;

    assign in_op  = s_tdata[1:0];
    assign in_row = s_tdata[11:2];
    assign in_col = s_tdata[21:12];
    assign in_val = s_tdata[53:22];

    assign row_ok = ({1'b0, in_row} < row_count_reg) && ({7'd0, in_row} < MAX_DIM_W);
    assign col_ok = ({1'b0, in_col} < column_count_reg) && ({7'd0, in_col} < MAX_DIM_W);
    assign in_err = (in_op == OP_UNUSED) || !row_ok || ((in_op != OP_COUNT) && !col_ok);

    assign key_hit = (rd_data_reg.row == row_reg) && (rd_data_reg.col == col_reg);
    assign key_lt  = (row_reg < rd_data_reg.row) ||
                     ((row_reg == rd_data_reg.row) && (col_reg < rd_data_reg.col));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_DONE);
    assign m_tdata  = {7'd0, res_status_reg, res_nz_reg, res_value_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = {21'd0, row_count_reg};
            REG_COLUMN_COUNT: prdata = {21'd0, column_count_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_RESET;
            column_count_reg <= DIM_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ROW_COUNT)
            begin
                row_count_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                column_count_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        wdest_next      = wdest_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        old_val_next    = old_val_reg;
        nz_next         = nz_reg;
        res_value_next  = res_value_reg;
        res_nz_next     = res_nz_reg;
        res_status_next = res_status_reg;
        rd_addr         = k_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = wdest_reg;
        wr_data         = rd_data_reg;
        stop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next         = in_op;
                    row_next        = in_row;
                    col_next        = in_col;
                    val_next        = in_val;
                    nz_next         = '0;
                    hit_next        = 1'b0;
                    old_val_next    = '0;
                    k_next          = '0;
                    pend_next       = 1'b0;
                    res_value_next  = '0;
                    res_nz_next     = '0;
                    res_status_next = ST_OK;
                    if (in_err)
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (pend_reg)
                begin
                    if (op_reg == OP_COUNT)
                    begin
                        if (rd_data_reg.row > row_reg)
                        begin
                            stop = 1'b1;
                        end
                        else if ((rd_data_reg.row == row_reg) && (nz_reg != NZ_MAX))
                        begin
                            nz_next = nz_reg + 1'b1;
                        end
                    end
                    else if (key_hit)
                    begin
                        stop         = 1'b1;
                        hit_next     = 1'b1;
                        pos_next     = k_reg - 1'b1;
                        old_val_next = rd_data_reg.val;
                    end
                    else if (key_lt)
                    begin
                        stop     = 1'b1;
                        pos_next = k_reg - 1'b1;
                    end
                end
                if (!stop)
                begin
                    if (k_reg < count_reg)
                    begin
                        rd_addr   = k_reg[AW-1:0];
                        k_next    = k_reg + 1'b1;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (!pend_reg)
                        begin
                            stop     = 1'b1;
                            pos_next = k_reg;
                        end
                    end
                end
                if (stop)
                begin
                    pend_next  = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_READ:
                    begin
                        res_value_next = hit_reg ? old_val_reg : '0;
                    end
                    OP_COUNT:
                    begin
                        res_nz_next = nz_reg;
                    end
                    OP_WRITE:
                    begin
                        if (hit_reg)
                        begin
                            res_value_next = old_val_reg;
                            if (val_reg != '0)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = pos_reg[AW-1:0];
                                wr_data = '{row: row_reg, col: col_reg, val: val_reg};
                            end
                            else
                            begin
                                k_next     = pos_reg + 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_DEL;
                            end
                        end
                        else if (val_reg != '0)
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                pend_next  = 1'b0;
                                state_next = S_INS;
                            end
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_RANGE;
                    end
                endcase
            end

            S_DEL:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wdest_reg;
                    wr_data = rd_data_reg;
                end
                if (k_reg < count_reg)
                begin
                    rd_addr    = k_reg[AW-1:0];
                    wdest_next = AW'(k_reg - 1'b1);
                    k_next     = k_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_INS:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wdest_reg;
                    wr_data = rd_data_reg;
                end
                if (k_reg > pos_reg)
                begin
                    rd_addr    = AW'(k_reg - 1'b1);
                    wdest_next = k_reg[AW-1:0];
                    k_next     = k_reg - 1'b1;
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = pos_reg[AW-1:0];
                        wr_data    = '{row: row_reg, col: col_reg, val: val_reg};
                        count_next = count_reg + 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            k_reg     <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        wdest_reg      <= wdest_next;
        hit_reg        <= hit_next;
        op_reg         <= op_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        old_val_reg    <= old_val_next;
        nz_reg         <= nz_next;
        res_value_reg  <= res_value_next;
        res_nz_reg     <= res_nz_next;
        res_status_reg <= res_status_next;
    end

endmodule
